>>> hw/rtl/mlptw_pkg.sv
// ----------------------------------------------------------------------------
// mlptw_pkg
// Shared types and constants of the multi-level page table walker.
// ----------------------------------------------------------------------------
package mlptw_pkg;

    // payload widths of the channels
    localparam int VA_W         = 32;
    localparam int FRAME_NUM_W  = 20;
    localparam int FRAMES_CNT_W = 21;

    // configuration geometry
    localparam int NUM_LVL    = 4;
    localparam int LVL_IDX_W  = 2;
    localparam int LC_W       = 3;
    localparam int LB_W       = 5;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 5;

    // register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_LEVEL_COUNT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LEVEL0_BITS = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LEVEL1_BITS = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LEVEL2_BITS = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_LEVEL3_BITS = 3'd4;

    // datapath widths
    localparam int IDX_W = (1 << LB_W) - 1; // widest level index
    localparam int SLOT_W = IDX_W + 1;      // node base plus index
    localparam int ALU_W = IDX_W + 3;       // sum of up to three node sizes plus pool use
    localparam int TOT_W = 7;               // sum of four level widths
    localparam int POS_W = 7;               // bit position within the address

    typedef struct packed {
        logic [LC_W-1:0]              level_count;
        logic [NUM_LVL-1:0][LB_W-1:0] level_bits;
    } cfg_t;

    // shared add and compare unit
    typedef struct packed {
        logic [ALU_W-1:0] a;
        logic [ALU_W-1:0] b;
        logic [ALU_W-1:0] lim;
        logic             sub;
    } alu_req_t;

    typedef struct packed {
        logic [ALU_W-1:0] sum;
        logic             over;
    } alu_rsp_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SUM,
        ST_ROOT,
        ST_INDEX,
        ST_READ,
        ST_LOOKUP,
        ST_NEED,
        ST_AVAIL,
        ST_CHECK,
        ST_PTR,
        ST_USED,
        ST_SLOT,
        ST_LEAF,
        ST_DONE
    } state_t;

endpackage

>>> hw/rtl/mlptw_in_if.sv
// ----------------------------------------------------------------------------
// mlptw_in_if
// Request channel: one virtual address per transaction.
// ----------------------------------------------------------------------------
interface mlptw_in_if;

    logic                         valid;
    logic                         ready;
    logic [mlptw_pkg::VA_W-1:0]   virtual_address;

    modport source (output valid, output virtual_address, input ready);
    modport sink   (input valid, input virtual_address, output ready);

endinterface

>>> hw/rtl/mlptw_out_if.sv
// ----------------------------------------------------------------------------
// mlptw_out_if
// Response channel: frame number and status per transaction.
// ----------------------------------------------------------------------------
interface mlptw_out_if;

    logic                                 valid;
    logic                                 ready;
    logic [mlptw_pkg::FRAME_NUM_W-1:0]    frame_number;
    logic                                 hit;
    logic                                 error;
    logic [mlptw_pkg::FRAMES_CNT_W-1:0]   frames_allocated;

    modport source (output valid, output frame_number, output hit, output error,
                    output frames_allocated, input ready);
    modport sink   (input valid, input frame_number, input hit, input error,
                    input frames_allocated, output ready);

endinterface

>>> hw/rtl/mlptw_entry_ram.sv
// ----------------------------------------------------------------------------
// mlptw_entry_ram
// Entry pool: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module mlptw_entry_ram #(
    parameter int DEPTH  = 65536,
    parameter int ADDR_W = 16,
    parameter int DATA_W = 21
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

>>> hw/rtl/mlptw_alu.sv
// ----------------------------------------------------------------------------
// mlptw_alu
// Shared add/subtract unit with an upper-bound compare on the result.
// ----------------------------------------------------------------------------
module mlptw_alu (
    input  mlptw_pkg::alu_req_t cmd,
    output mlptw_pkg::alu_rsp_t res
);

    // one add or subtract, then one compare against the bound
    always_comb
    begin
        res.sum  = cmd.sub ? (cmd.a - cmd.b) : (cmd.a + cmd.b);
        res.over = (res.sum > cmd.lim);
    end

endmodule

>>> hw/rtl/mlptw_cfg_regs.sv
// ----------------------------------------------------------------------------
// mlptw_cfg_regs
// Geometry registers; any accepted write also requests a table clear.
// ----------------------------------------------------------------------------
module mlptw_cfg_regs (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                we,
    input  logic [mlptw_pkg::CFG_IDX_W-1:0]     index,
    input  logic [mlptw_pkg::CFG_DATA_W-1:0]    data,
    output mlptw_pkg::cfg_t                     cfg,
    output logic                                clear
);

    mlptw_pkg::cfg_t cfg_reg;
    mlptw_pkg::cfg_t cfg_next;

    // register write decode
    always_comb
    begin
        cfg_next = cfg_reg;
        if (we)
        begin
            unique case (index)
                mlptw_pkg::REG_LEVEL_COUNT: cfg_next.level_count   = data[mlptw_pkg::LC_W-1:0];
                mlptw_pkg::REG_LEVEL0_BITS: cfg_next.level_bits[0] = data;
                mlptw_pkg::REG_LEVEL1_BITS: cfg_next.level_bits[1] = data;
                mlptw_pkg::REG_LEVEL2_BITS: cfg_next.level_bits[2] = data;
                mlptw_pkg::REG_LEVEL3_BITS: cfg_next.level_bits[3] = data;
                default:                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.level_count <= mlptw_pkg::LC_W'(1);
            for (int i = 0; i < mlptw_pkg::NUM_LVL; i++)
            begin
                cfg_reg.level_bits[i] <= mlptw_pkg::LB_W'(8);
            end
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg   = cfg_reg;
    assign clear = we && (index <= mlptw_pkg::REG_LEVEL3_BITS);

endmodule

>>> hw/rtl/mlptw_seq.sv
// ----------------------------------------------------------------------------
// mlptw_seq
// Walk sequencer: drives the shared add/compare unit and the entry pool,
// one level step at a time, and holds the response register.
// ----------------------------------------------------------------------------
module mlptw_seq #(
    parameter int ADDR_BITS    = 32,
    parameter int MAX_LEVELS   = 4,
    parameter int POOL_ENTRIES = 65536,
    parameter int FRAME_BITS   = 20,
    parameter int PTR_W        = 16,
    parameter int PAY_W        = 20
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  mlptw_pkg::cfg_t         cfg,
    input  logic                    clear,
    mlptw_in_if.sink                req,
    mlptw_out_if.source             rsp,
    output logic                    mem_we,
    output logic [PTR_W-1:0]        mem_waddr,
    output logic [PAY_W:0]          mem_wdata,
    output logic                    mem_re,
    output logic [PTR_W-1:0]        mem_raddr,
    input  logic [PAY_W:0]          mem_rdata
);

    localparam int LVL_LIM = (MAX_LEVELS < mlptw_pkg::NUM_LVL) ? MAX_LEVELS : mlptw_pkg::NUM_LVL;
    localparam int NF_W    = FRAME_BITS + 1;
    localparam int CNT_W   = $clog2(POOL_ENTRIES + 1);
    localparam int ALU_W   = mlptw_pkg::ALU_W;
    localparam int IDX_W   = mlptw_pkg::IDX_W;
    localparam int LC_W    = mlptw_pkg::LC_W;

    mlptw_pkg::state_t state_reg, state_next;
    logic [LC_W-1:0]               k_reg, k_next;
    logic [LC_W-1:0]               nl_reg, nl_next;
    logic [LC_W-1:0]               missing_reg, missing_next;
    logic [ADDR_BITS-1:0]          addr_reg, addr_next;
    logic [mlptw_pkg::POS_W-1:0]   pos_reg, pos_next;
    logic [mlptw_pkg::TOT_W-1:0]   total_reg, total_next;
    logic [IDX_W-1:0]              idx_reg [mlptw_pkg::NUM_LVL];
    logic [IDX_W-1:0]              idx_next [mlptw_pkg::NUM_LVL];
    logic [PTR_W-1:0]              base_reg, base_next;
    logic [mlptw_pkg::SLOT_W-1:0]  slot_reg, slot_next;
    logic [ALU_W-1:0]              need_reg, need_next;
    logic [PTR_W-1:0]              nb_reg, nb_next;
    logic [CNT_W-1:0]              pool_used_reg, pool_used_next;
    logic [NF_W-1:0]               next_frame_reg, next_frame_next;
    logic [PTR_W-1:0]              clr_reg, clr_next;
    logic [mlptw_pkg::FRAME_NUM_W-1:0]  res_frame_reg, res_frame_next;
    logic                          res_hit_reg, res_hit_next;
    logic                          res_err_reg, res_err_next;
    logic                          out_valid_reg, out_valid_next;
    logic [mlptw_pkg::FRAME_NUM_W-1:0]  out_frame_reg, out_frame_next;
    logic                          out_hit_reg, out_hit_next;
    logic                          out_err_reg, out_err_next;
    logic [mlptw_pkg::FRAMES_CNT_W-1:0] out_count_reg, out_count_next;

    mlptw_pkg::alu_req_t alu_cmd;
    mlptw_pkg::alu_rsp_t alu_res;

    logic [mlptw_pkg::LVL_IDX_W-1:0] lvl;
    logic [mlptw_pkg::LVL_IDX_W-1:0] lvl_up;
    logic [mlptw_pkg::LB_W-1:0]      cur_bits;
    logic [ALU_W-1:0]                root_size;
    logic [mlptw_pkg::POS_W-1:0]     sh;
    logic [ADDR_BITS-1:0]            shifted;
    logic [IDX_W-1:0]                idx_mask;
    logic                            fail;

    mlptw_alu u_alu (
        .cmd (alu_cmd),
        .res (alu_res)
    );

    assign lvl       = k_reg[mlptw_pkg::LVL_IDX_W-1:0];
    assign lvl_up    = lvl + mlptw_pkg::LVL_IDX_W'(1);
    assign cur_bits  = cfg.level_bits[lvl];
    assign root_size = ALU_W'(1) << cfg.level_bits[0];
    assign sh        = alu_res.sum[mlptw_pkg::POS_W-1:0];
    assign shifted   = addr_reg >> sh;
    assign idx_mask  = IDX_W'((ALU_W'(1) << cur_bits) - ALU_W'(1));

    assign req.ready        = (state_reg == mlptw_pkg::ST_IDLE);
    assign rsp.valid        = out_valid_reg;
    assign rsp.frame_number = out_frame_reg;
    assign rsp.hit          = out_hit_reg;
    assign rsp.error        = out_err_reg;
    assign rsp.frames_allocated = out_count_reg;

    // sequencer: next state, unit operands and memory accesses
    always_comb
    begin
        state_next      = state_reg;
        k_next          = k_reg;
        nl_next         = nl_reg;
        missing_next    = missing_reg;
        addr_next       = addr_reg;
        pos_next        = pos_reg;
        total_next      = total_reg;
        idx_next        = idx_reg;
        base_next       = base_reg;
        slot_next       = slot_reg;
        need_next       = need_reg;
        nb_next         = nb_reg;
        pool_used_next  = pool_used_reg;
        next_frame_next = next_frame_reg;
        clr_next        = clr_reg;
        res_frame_next  = res_frame_reg;
        res_hit_next    = res_hit_reg;
        res_err_next    = res_err_reg;
        out_valid_next  = out_valid_reg;
        out_frame_next  = out_frame_reg;
        out_hit_next    = out_hit_reg;
        out_err_next    = out_err_reg;
        out_count_next  = out_count_reg;
        alu_cmd         = '0;
        mem_we          = 1'b0;
        mem_waddr       = clr_reg;
        mem_wdata       = '0;
        mem_re          = 1'b0;
        mem_raddr       = alu_res.sum[PTR_W-1:0];
        fail            = 1'b0;

        // response register drains independently of the walk
        if (out_valid_reg && rsp.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            mlptw_pkg::ST_CLEAR:
            begin
                mem_we   = 1'b1;
                clr_next = clr_reg + PTR_W'(1);
                if (clr_reg == PTR_W'(POOL_ENTRIES - 1))
                begin
                    state_next = mlptw_pkg::ST_IDLE;
                end
            end
            mlptw_pkg::ST_IDLE:
            begin
                if (req.valid)
                begin
                    addr_next  = ADDR_BITS'(req.virtual_address);
                    k_next     = '0;
                    total_next = '0;
                    if (cfg.level_count == '0)
                    begin
                        nl_next = LC_W'(1);
                    end
                    else if (cfg.level_count > LC_W'(LVL_LIM))
                    begin
                        nl_next = LC_W'(LVL_LIM);
                    end
                    else
                    begin
                        nl_next = cfg.level_count;
                    end
                    state_next = mlptw_pkg::ST_SUM;
                end
            end
            // total of the level widths, bound is the address width
            mlptw_pkg::ST_SUM:
            begin
                alu_cmd.a   = ALU_W'(total_reg);
                alu_cmd.b   = ALU_W'(cur_bits);
                alu_cmd.lim = ALU_W'(ADDR_BITS);
                total_next  = alu_res.sum[mlptw_pkg::TOT_W-1:0];
                k_next      = k_reg + LC_W'(1);
                if (k_reg == nl_reg - LC_W'(1))
                begin
                    k_next = '0;
                    if (alu_res.over)
                    begin
                        fail = 1'b1;
                    end
                    else
                    begin
                        state_next = mlptw_pkg::ST_ROOT;
                    end
                end
            end
            // root node must fit in the pool
            mlptw_pkg::ST_ROOT:
            begin
                alu_cmd.a   = root_size;
                alu_cmd.lim = ALU_W'(POOL_ENTRIES);
                if (alu_res.over)
                begin
                    fail = 1'b1;
                end
                else
                begin
                    pos_next   = mlptw_pkg::POS_W'(ADDR_BITS);
                    state_next = mlptw_pkg::ST_INDEX;
                end
            end
            // cut one level index from the top of the address
            mlptw_pkg::ST_INDEX:
            begin
                alu_cmd.a     = ALU_W'(pos_reg);
                alu_cmd.b     = ALU_W'(cur_bits);
                alu_cmd.sub   = 1'b1;
                alu_cmd.lim   = '1;
                idx_next[lvl] = IDX_W'(shifted) & idx_mask;
                pos_next      = sh;
                k_next        = k_reg + LC_W'(1);
                if (k_reg == nl_reg - LC_W'(1))
                begin
                    k_next     = '0;
                    base_next  = '0;
                    state_next = mlptw_pkg::ST_READ;
                end
            end
            // slot address of this level, then issue the pool read
            mlptw_pkg::ST_READ:
            begin
                alu_cmd.a   = ALU_W'(base_reg);
                alu_cmd.b   = ALU_W'(idx_reg[lvl]);
                alu_cmd.lim = ALU_W'(POOL_ENTRIES - 1);
                slot_next   = alu_res.sum[mlptw_pkg::SLOT_W-1:0];
                if (alu_res.over)
                begin
                    fail = 1'b1;
                end
                else
                begin
                    mem_re     = 1'b1;
                    state_next = mlptw_pkg::ST_LOOKUP;
                end
            end
            mlptw_pkg::ST_LOOKUP:
            begin
                if (!mem_rdata[PAY_W])
                begin
                    missing_next = k_reg;
                    k_next       = k_reg + LC_W'(1);
                    need_next    = '0;
                    state_next   = mlptw_pkg::ST_NEED;
                end
                else if (k_reg == nl_reg - LC_W'(1))
                begin
                    res_frame_next = mlptw_pkg::FRAME_NUM_W'(mem_rdata[PAY_W-1:0]);
                    res_hit_next   = 1'b1;
                    res_err_next   = 1'b0;
                    state_next     = mlptw_pkg::ST_DONE;
                end
                else
                begin
                    base_next  = PTR_W'(mem_rdata[PAY_W-1:0]);
                    k_next     = k_reg + LC_W'(1);
                    state_next = mlptw_pkg::ST_READ;
                end
            end
            // pool space the missing interior nodes would take
            mlptw_pkg::ST_NEED:
            begin
                if (k_reg < nl_reg)
                begin
                    alu_cmd.a   = need_reg;
                    alu_cmd.b   = ALU_W'(1) << cur_bits;
                    alu_cmd.lim = '1;
                    need_next   = alu_res.sum;
                    k_next      = k_reg + LC_W'(1);
                end
                else
                begin
                    state_next = mlptw_pkg::ST_AVAIL;
                end
            end
            mlptw_pkg::ST_AVAIL:
            begin
                alu_cmd.a   = need_reg;
                alu_cmd.b   = ALU_W'(pool_used_reg);
                alu_cmd.lim = '1;
                need_next   = alu_res.sum;
                state_next  = mlptw_pkg::ST_CHECK;
            end
            // need plus used plus root against the pool, and frame supply
            mlptw_pkg::ST_CHECK:
            begin
                alu_cmd.a   = need_reg;
                alu_cmd.b   = root_size;
                alu_cmd.lim = ALU_W'(POOL_ENTRIES);
                if (alu_res.over || next_frame_reg[FRAME_BITS])
                begin
                    fail = 1'b1;
                end
                else
                begin
                    k_next     = missing_reg;
                    state_next = mlptw_pkg::ST_PTR;
                end
            end
            // new interior node from the bump pointer, linked into the slot
            mlptw_pkg::ST_PTR:
            begin
                if (k_reg + LC_W'(1) < nl_reg)
                begin
                    alu_cmd.a   = root_size;
                    alu_cmd.b   = ALU_W'(pool_used_reg);
                    alu_cmd.lim = '1;
                    nb_next     = alu_res.sum[PTR_W-1:0];
                    mem_we      = 1'b1;
                    mem_waddr   = slot_reg[PTR_W-1:0];
                    mem_wdata   = {1'b1, PAY_W'(alu_res.sum[PTR_W-1:0])};
                    state_next  = mlptw_pkg::ST_USED;
                end
                else
                begin
                    state_next = mlptw_pkg::ST_LEAF;
                end
            end
            mlptw_pkg::ST_USED:
            begin
                alu_cmd.a      = ALU_W'(pool_used_reg);
                alu_cmd.b      = ALU_W'(1) << cfg.level_bits[lvl_up];
                alu_cmd.lim    = '1;
                pool_used_next = alu_res.sum[CNT_W-1:0];
                state_next     = mlptw_pkg::ST_SLOT;
            end
            mlptw_pkg::ST_SLOT:
            begin
                alu_cmd.a   = ALU_W'(nb_reg);
                alu_cmd.b   = ALU_W'(idx_reg[lvl_up]);
                alu_cmd.lim = '1;
                slot_next   = alu_res.sum[mlptw_pkg::SLOT_W-1:0];
                k_next      = k_reg + LC_W'(1);
                state_next  = mlptw_pkg::ST_PTR;
            end
            // leaf gets the next frame number
            mlptw_pkg::ST_LEAF:
            begin
                alu_cmd.a   = ALU_W'(slot_reg);
                alu_cmd.lim = ALU_W'(POOL_ENTRIES - 1);
                if (alu_res.over)
                begin
                    fail = 1'b1;
                end
                else
                begin
                    mem_we          = 1'b1;
                    mem_waddr       = slot_reg[PTR_W-1:0];
                    mem_wdata       = {1'b1, PAY_W'(next_frame_reg)};
                    res_frame_next  = mlptw_pkg::FRAME_NUM_W'(next_frame_reg);
                    res_hit_next    = 1'b0;
                    res_err_next    = 1'b0;
                    next_frame_next = next_frame_reg + NF_W'(1);
                    state_next      = mlptw_pkg::ST_DONE;
                end
            end
            // hand the result to the response register once it is free
            mlptw_pkg::ST_DONE:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next = 1'b1;
                    out_frame_next = res_frame_reg;
                    out_hit_next   = res_hit_reg;
                    out_err_next   = res_err_reg;
                    out_count_next = mlptw_pkg::FRAMES_CNT_W'(next_frame_reg);
                    state_next     = mlptw_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = mlptw_pkg::ST_IDLE;
            end
        endcase

        // error result, nothing allocated
        if (fail)
        begin
            res_frame_next = '0;
            res_hit_next   = 1'b0;
            res_err_next   = 1'b1;
            state_next     = mlptw_pkg::ST_DONE;
        end

        // a register write empties the table and restarts the clearing pass
        if (clear)
        begin
            state_next      = mlptw_pkg::ST_CLEAR;
            clr_next        = '0;
            pool_used_next  = '0;
            next_frame_next = '0;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= mlptw_pkg::ST_CLEAR;
            k_reg          <= '0;
            pool_used_reg  <= '0;
            next_frame_reg <= '0;
            clr_reg        <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            k_reg          <= k_next;
            pool_used_reg  <= pool_used_next;
            next_frame_reg <= next_frame_next;
            clr_reg        <= clr_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // walk datapath and response payload
    always_ff @(posedge clk)
    begin
        nl_reg        <= nl_next;
        missing_reg   <= missing_next;
        addr_reg      <= addr_next;
        pos_reg       <= pos_next;
        total_reg     <= total_next;
        idx_reg       <= idx_next;
        base_reg      <= base_next;
        slot_reg      <= slot_next;
        need_reg      <= need_next;
        nb_reg        <= nb_next;
        res_frame_reg <= res_frame_next;
        res_hit_reg   <= res_hit_next;
        res_err_reg   <= res_err_next;
        out_frame_reg <= out_frame_next;
        out_hit_reg   <= out_hit_next;
        out_err_reg   <= out_err_next;
        out_count_reg <= out_count_next;
    end

`ifndef SYNTHESIS
    // frame counter only ever steps by one outside a clear
    a_frame_step: assert property (@(posedge clk) disable iff (!rst_n)
        !clear |=> (next_frame_reg == $past(next_frame_reg)) ||
                   (next_frame_reg == $past(next_frame_reg) + NF_W'(1)))
        else $error("frame counter jumped");

    // bump pointer never runs past the pool
    a_pool_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (root_size <= ALU_W'(POOL_ENTRIES)) |->
        (ALU_W'(pool_used_reg) + root_size <= ALU_W'(POOL_ENTRIES)))
        else $error("pool use beyond pool size");

    // a response is never both a hit and an error
    a_hit_err: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid |-> !(rsp.hit && rsp.error))
        else $error("hit and error together");

    // a fresh mapping implies at least one frame handed out
    a_miss_count: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && !rsp.hit && !rsp.error) |-> (rsp.frames_allocated != '0))
        else $error("new mapping with zero frames allocated");

    // pool writes come only from clearing or allocation
    a_write_src: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> (state_reg == mlptw_pkg::ST_CLEAR || state_reg == mlptw_pkg::ST_PTR ||
                    state_reg == mlptw_pkg::ST_LEAF))
        else $error("pool write outside clear or allocation");
`endif

endmodule

>>> hw/rtl/multilevel_page_table_walker_top.sv
// ----------------------------------------------------------------------------
// multilevel_page_table_walker_top
// Multi-level radix page table walker with on-demand allocation.
// ----------------------------------------------------------------------------
// Each request carries one virtual address and gets exactly one response.
// The walk handles one address at a time through a single add/compare unit
// and an entry pool with one write port and one read port with registered
// read data. A finished response waits in its own register
// while the next request is taken. After reset, and after every
// configuration write, the pool is swept once to mark all entries invalid;
// no request is taken during the sweep (configuration writes still are).
// A configuration write empties the table and resets the frame counter.
module multilevel_page_table_walker_top #(
    parameter int ADDR_BITS    = 32,
    parameter int MAX_LEVELS   = 4,
    parameter int POOL_ENTRIES = 65536,
    parameter int FRAME_BITS   = 20
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [mlptw_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [mlptw_pkg::CFG_DATA_W-1:0]    cfg_data,
    mlptw_in_if.sink                            req,
    mlptw_out_if.source                         rsp
);

    localparam int PTR_W = $clog2(POOL_ENTRIES);
    localparam int PAY_W = (PTR_W > FRAME_BITS) ? PTR_W : FRAME_BITS;

    mlptw_pkg::cfg_t     cfg;
    logic                clear;
    logic                mem_we;
    logic [PTR_W-1:0]    mem_waddr;
    logic [PAY_W:0]      mem_wdata;
    logic                mem_re;
    logic [PTR_W-1:0]    mem_raddr;
    logic [PAY_W:0]      mem_rdata;

    // geometry registers
    mlptw_cfg_regs u_cfg (
        .clk   (clk),
        .rst_n (rst_n),
        .we    (cfg_we),
        .index (cfg_index),
        .data  (cfg_data),
        .cfg   (cfg),
        .clear (clear)
    );

    // entry pool: valid bit over child base or frame number
    mlptw_entry_ram #(
        .DEPTH  (POOL_ENTRIES),
        .ADDR_W (PTR_W),
        .DATA_W (PAY_W + 1)
    ) u_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // walk sequencer
    mlptw_seq #(
        .ADDR_BITS    (ADDR_BITS),
        .MAX_LEVELS   (MAX_LEVELS),
        .POOL_ENTRIES (POOL_ENTRIES),
        .FRAME_BITS   (FRAME_BITS),
        .PTR_W        (PTR_W),
        .PAY_W        (PAY_W)
    ) u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .clear     (clear),
        .req       (req),
        .rsp       (rsp),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata),
        .mem_re    (mem_re),
        .mem_raddr (mem_raddr),
        .mem_rdata (mem_rdata)
    );

endmodule

>>> test/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the multi-level page table walker. Addresses are
// sent through several table geometries and pacing patterns, and each
// response is checked in order against a walk of a local copy of the table.
// ----------------------------------------------------------------------------
module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int ADDR_BITS    = 32;
    localparam int MAX_LEVELS   = 4;
    localparam int POOL_ENTRIES = 65536;
    localparam int FRAME_BITS   = 20;

    // pacing of the two channels
    typedef enum logic [1:0] {
        PACE_FULL,
        PACE_SRC_IDLE,
        PACE_SNK_STALL,
        PACE_BOTH
    } pace_t;

    typedef struct packed {
        logic [mlptw_pkg::FRAME_NUM_W-1:0]  frame_number;
        logic                               hit;
        logic                               error;
        logic [mlptw_pkg::FRAMES_CNT_W-1:0] frames_allocated;
    } xlat_t;

    logic                             clk = 1'b0;
    logic                             rst_n;
    logic                             cfg_we;
    logic [mlptw_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [mlptw_pkg::CFG_DATA_W-1:0] cfg_data;

    mlptw_in_if  va_if ();
    mlptw_out_if pf_if ();

    // shadow of the table geometry and contents
    logic [mlptw_pkg::LC_W-1:0]  tbl_level_count;
    logic [mlptw_pkg::LB_W-1:0]  tbl_level_bits [mlptw_pkg::NUM_LVL];
    int unsigned                 tbl_entry [longint unsigned];
    longint unsigned             tbl_pool_used;
    longint unsigned             tbl_next_frame;

    logic [mlptw_pkg::VA_W-1:0]  va_backlog [$];
    logic [mlptw_pkg::VA_W-1:0]  recent_va [$];
    xlat_t                       pending_xlat [$];
    pace_t                       pace;
    bit                          va_taken = 1'b0;
    int                          mismatch_count = 0;

    multilevel_page_table_walker_top #(
        .ADDR_BITS    (ADDR_BITS),
        .MAX_LEVELS   (MAX_LEVELS),
        .POOL_ENTRIES (POOL_ENTRIES),
        .FRAME_BITS   (FRAME_BITS)
    ) uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req       (va_if),
        .rsp       (pf_if)
    );

    // clock, 10 ns period
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // walk the shadow table for one address, allocating as the block would
    function automatic xlat_t translate_address(logic [mlptw_pkg::VA_W-1:0] va);
        xlat_t           fault;
        xlat_t           res;
        longint unsigned lvl_index [mlptw_pkg::NUM_LVL];
        longint unsigned levels, total, root_size, pos, base, slot;
        longint unsigned need, avail, node_base;
        int unsigned     e;
        int              missing;
        int              k;
        fault.frame_number     = '0;
        fault.hit              = 1'b0;
        fault.error            = 1'b1;
        fault.frames_allocated = tbl_next_frame[mlptw_pkg::FRAMES_CNT_W-1:0];

        // out-of-range level counts are clamped
        levels = tbl_level_count;
        if (levels < 1)
            levels = 1;
        if (levels > MAX_LEVELS)
            levels = MAX_LEVELS;
        if (levels > mlptw_pkg::NUM_LVL)
            levels = mlptw_pkg::NUM_LVL;

        total = 0;
        for (k = 0; k < levels; k++)
            total += tbl_level_bits[k];
        if (total > ADDR_BITS)
            return fault;

        root_size = 64'd1 << tbl_level_bits[0];
        if (root_size > POOL_ENTRIES)
            return fault;

        // index bits from the top of the address downward
        pos = ADDR_BITS;
        for (k = 0; k < levels; k++)
        begin
            pos = pos - tbl_level_bits[k];
            lvl_index[k] = (64'(va) >> pos) & ((64'd1 << tbl_level_bits[k]) - 1);
        end

        // look up until the first missing entry
        base    = 0;
        slot    = 0;
        missing = int'(levels);
        for (k = 0; k < levels; k++)
        begin
            slot = base + lvl_index[k];
            if (slot >= POOL_ENTRIES)
                return fault;
            if (!tbl_entry.exists(slot))
            begin
                missing = k;
                break;
            end
            e = tbl_entry[slot];
            if (k == levels - 1)
            begin
                res.frame_number     = e[mlptw_pkg::FRAME_NUM_W-1:0];
                res.hit              = 1'b1;
                res.error            = 1'b0;
                res.frames_allocated = tbl_next_frame[mlptw_pkg::FRAMES_CNT_W-1:0];
                return res;
            end
            base = e;
        end

        // nodes still to create must fit, and a frame must be left
        need = 0;
        for (k = missing + 1; k < levels; k++)
            need += 64'd1 << tbl_level_bits[k];
        avail = 0;
        if (root_size + tbl_pool_used <= POOL_ENTRIES)
            avail = POOL_ENTRIES - root_size - tbl_pool_used;
        if (need > avail || tbl_next_frame >= (64'd1 << FRAME_BITS))
            return fault;

        for (k = missing; k + 1 < levels; k++)
        begin
            node_base       = root_size + tbl_pool_used;
            tbl_entry[slot] = int'(node_base);
            tbl_pool_used  += 64'd1 << tbl_level_bits[k + 1];
            slot            = node_base + lvl_index[k + 1];
        end
        if (slot >= POOL_ENTRIES)
            return fault;
        tbl_entry[slot] = int'(tbl_next_frame);
        tbl_next_frame++;

        res.frame_number     = fault.frame_number;
        res.frame_number     = tbl_next_frame[mlptw_pkg::FRAME_NUM_W-1:0] - 1'b1;
        res.hit              = 1'b0;
        res.error            = 1'b0;
        res.frames_allocated = tbl_next_frame[mlptw_pkg::FRAMES_CNT_W-1:0];
        return res;
    endfunction

    // request driver: hold an address until accepted, then next one or idle
    always @(negedge clk)
    begin : va_driver
        if (!rst_n)
        begin
            va_if.valid <= 1'b0;
        end
        else if (!va_if.valid || va_taken)
        begin
            va_taken = 1'b0;
            if (va_backlog.size() != 0 &&
                !((pace == PACE_SRC_IDLE && $urandom_range(0, 99) < 83) ||
                  (pace == PACE_BOTH && $urandom_range(0, 99) < 25)))
            begin
                va_if.valid           <= 1'b1;
                va_if.virtual_address <= va_backlog.pop_front();
            end
            else
            begin
                va_if.valid <= 1'b0;
            end
        end

        // response back-pressure
        pf_if.ready <= !((pace == PACE_SNK_STALL && $urandom_range(0, 99) < 83) ||
                         (pace == PACE_BOTH && $urandom_range(0, 99) < 25));
    end

    // monitor: check responses, predict accepted requests
    always @(posedge clk)
    begin : xlat_monitor
        xlat_t want;
        xlat_t got;
        if (rst_n)
        begin
            if (pf_if.valid && pf_if.ready)
            begin
                got.frame_number     = pf_if.frame_number;
                got.hit              = pf_if.hit;
                got.error            = pf_if.error;
                got.frames_allocated = pf_if.frames_allocated;
                if (pending_xlat.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("%0t: response with no request outstanding", $time);
                end
                else
                begin
                    want = pending_xlat.pop_front();
                    if (got.frame_number !== want.frame_number || got.hit !== want.hit ||
                        got.error !== want.error ||
                        got.frames_allocated !== want.frames_allocated)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                        begin
                            $display("%0t: expected frame=%h hit=%b error=%b frames=%0d",
                                     $time, want.frame_number, want.hit, want.error,
                                     want.frames_allocated);
                            $display("%0t: actual   frame=%h hit=%b error=%b frames=%0d",
                                     $time, got.frame_number, got.hit, got.error,
                                     got.frames_allocated);
                        end
                    end
                end
            end

            if (va_if.valid && va_if.ready)
            begin
                pending_xlat.push_back(translate_address(va_if.virtual_address));
                va_taken = 1'b1;
            end
        end
    end

    // one register write; any write empties the table
    task automatic write_reg(logic [mlptw_pkg::CFG_IDX_W-1:0] index,
                             logic [mlptw_pkg::CFG_DATA_W-1:0] value);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        @(negedge clk);
        cfg_we    <= 1'b0;
        if (index == mlptw_pkg::REG_LEVEL_COUNT)
            tbl_level_count = value[mlptw_pkg::LC_W-1:0];
        else
            tbl_level_bits[index - mlptw_pkg::REG_LEVEL0_BITS] = value;
        tbl_entry.delete();
        tbl_pool_used  = 0;
        tbl_next_frame = 0;
        recent_va.delete();
    endtask

    task automatic load_geometry(logic [mlptw_pkg::CFG_DATA_W-1:0] lc,
                                 logic [mlptw_pkg::CFG_DATA_W-1:0] b0,
                                 logic [mlptw_pkg::CFG_DATA_W-1:0] b1,
                                 logic [mlptw_pkg::CFG_DATA_W-1:0] b2,
                                 logic [mlptw_pkg::CFG_DATA_W-1:0] b3);
        write_reg(mlptw_pkg::REG_LEVEL_COUNT, lc);
        write_reg(mlptw_pkg::REG_LEVEL0_BITS, b0);
        write_reg(mlptw_pkg::REG_LEVEL1_BITS, b1);
        write_reg(mlptw_pkg::REG_LEVEL2_BITS, b2);
        write_reg(mlptw_pkg::REG_LEVEL3_BITS, b3);
        @(posedge clk);
    endtask

    task automatic queue_va(logic [mlptw_pkg::VA_W-1:0] va);
        va_backlog.push_back(va);
        recent_va.push_back(va);
        if (recent_va.size() > 16)
            void'(recent_va.pop_front());
    endtask

    // mostly revisits and shared prefixes of recent pages, the rest fresh
    task automatic queue_random(int n);
        logic [mlptw_pkg::VA_W-1:0] va;
        logic [mlptw_pkg::VA_W-1:0] keep;
        int                         pick;
        @(posedge clk);
        for (int i = 0; i < n; i++)
        begin
            va   = $urandom();
            pick = $urandom_range(0, 9);
            if (recent_va.size() != 0 && pick < 6)
            begin
                if (pick < 3)
                    keep = '1;
                else
                    keep = ~(32'hFFFF_FFFF >> $urandom_range(0, 32));
                va = (recent_va[$urandom_range(0, recent_va.size() - 1)] & keep) |
                     (va & ~keep);
            end
            queue_va(va);
        end
    endtask

    // wait until every address is taken and every response is back
    task automatic drain();
        while (va_backlog.size() != 0 || va_if.valid || pending_xlat.size() != 0)
            @(posedge clk);
    endtask

    initial
    begin : stimulus
        rst_n                 = 1'b0;
        cfg_we                = 1'b0;
        cfg_index             = mlptw_pkg::REG_LEVEL_COUNT;
        cfg_data              = '0;
        va_if.valid           = 1'b0;
        va_if.virtual_address = '0;
        pf_if.ready           = 1'b0;
        pace                  = PACE_FULL;
        tbl_level_count       = 3'd1;
        for (int i = 0; i < mlptw_pkg::NUM_LVL; i++)
            tbl_level_bits[i] = 5'd8;
        tbl_pool_used  = 0;
        tbl_next_frame = 0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // reset geometry: single level of 8 bits
        @(posedge clk);
        queue_va(32'h0000_0000);
        queue_va(32'hFFFF_FFFF);
        queue_va(32'h00FF_FFFF);
        queue_va(32'hFF00_0000);
        queue_va(32'h8000_0000);
        queue_va(32'h7FFF_FFFF);
        queue_va(32'h0000_0001);
        queue_random(40);
        drain();

        // four levels filling the whole address, misses at every depth
        load_geometry(5'd4, 5'd8, 5'd8, 5'd8, 5'd8);
        pace = PACE_SRC_IDLE;
        queue_va(32'h0000_0000);
        queue_va(32'h0000_0000);
        queue_va(32'h0000_0001);
        queue_va(32'h0000_0100);
        queue_va(32'h0001_0000);
        queue_va(32'h0100_0000);
        queue_va(32'hFFFF_FFFF);
        queue_va(32'hFFFF_FFFE);
        queue_random(60);
        drain();
        pace = PACE_BOTH;
        queue_random(60);
        drain();

        // big second-level nodes: the second one no longer fits in the pool
        load_geometry(5'd2, 5'd1, 5'd15, 5'd31, 5'd31);
        pace = PACE_SNK_STALL;
        queue_va(32'h0000_0000);
        queue_va(32'h8000_0000);
        queue_va(32'h7FFF_FFFF);
        queue_va(32'h0000_0000);
        queue_va(32'hC000_0000);
        queue_random(50);
        drain();

        // single-entry root, pool runs out after fifteen leaf nodes
        load_geometry(5'd3, 5'd0, 5'd4, 5'd12, 5'd16);
        pace = PACE_BOTH;
        queue_random(70);
        drain();

        // level count zero taken as one, root spans the whole pool
        load_geometry(5'd0, 5'd16, 5'd1, 5'd2, 5'd3);
        pace = PACE_FULL;
        queue_va(32'h0000_0000);
        queue_va(32'hFFFF_FFFF);
        queue_va(32'hFFFF_0000);
        queue_random(50);
        drain();

        // root larger than the pool
        load_geometry(5'd1, 5'd17, 5'd31, 5'd31, 5'd31);
        pace = PACE_SRC_IDLE;
        queue_va(32'h0000_0000);
        queue_va(32'hFFFF_FFFF);
        queue_va(32'h8000_0000);
        queue_random(10);
        drain();

        // level count above the limit, level bits one over the address width
        load_geometry(5'd5, 5'd8, 5'd8, 5'd8, 5'd9);
        pace = PACE_SNK_STALL;
        queue_random(10);
        drain();

        // small table with many revisits, all pacing patterns
        load_geometry(5'd7, 5'd6, 5'd6, 5'd6, 5'd6);
        pace = PACE_FULL;
        queue_random(50);
        drain();
        pace = PACE_SNK_STALL;
        queue_random(50);
        drain();
        pace = PACE_BOTH;
        queue_random(50);
        drain();
        pace = PACE_SRC_IDLE;
        queue_random(50);
        drain();

        // let any stray response show up
        repeat (40) @(posedge clk);
        if (mismatch_count == 0 && pending_xlat.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    // watchdog
    initial
    begin : watchdog
        #25ms;
        $display("Test completed with failures");
        $finish;
    end

endmodule
